FILE: rtl/cplm_pkg.sv
`default_nettype none

package cplm_pkg;

  // idle counter width, the sample is taken modulo 2^COUNT_BITS
  localparam int COUNT_BITS = 32;
  localparam int IDLE_BITS  = 32;
  localparam int PCT_BITS   = 7;

  // 100 * x < 2^(COUNT_BITS + 7), so this holds the scaled value and the shifted divisor
  localparam int ALU_BITS = COUNT_BITS + 7;

  // 100 = 64 + 32 + 4
  localparam int MUL_SH_A = 6;
  localparam int MUL_SH_B = 5;
  localparam int MUL_SH_C = 2;

  localparam int STEP_BITS = $clog2(PCT_BITS);

  typedef struct packed {
    logic                  start;
    logic                  mode;
    logic [COUNT_BITS-1:0] sample;
  } core_req_t;

  typedef struct packed {
    logic                idle;
    logic                done;
    logic [PCT_BITS-1:0] usage_whole;
    logic [PCT_BITS-1:0] usage_hundredths;
    logic [PCT_BITS-1:0] peak_whole;
    logic [PCT_BITS-1:0] peak_hundredths;
  } core_stat_t;

endpackage

`default_nettype wire

FILE: rtl/cplm_sample_if.sv
`default_nettype none

interface cplm_sample_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [cplm_pkg::IDLE_BITS-1:0] idle_count;

  modport source(output valid, output mode, output idle_count, input ready);
  modport sink(input valid, input mode, input idle_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/cplm_result_if.sv
`default_nettype none

interface cplm_result_if;
  logic                          valid;
  logic                          ready;
  logic [cplm_pkg::PCT_BITS-1:0] usage_whole;
  logic [cplm_pkg::PCT_BITS-1:0] usage_hundredths;
  logic [cplm_pkg::PCT_BITS-1:0] peak_whole;
  logic [cplm_pkg::PCT_BITS-1:0] peak_hundredths;

  modport source(output valid, output usage_whole, output usage_hundredths,
                 output peak_whole, output peak_hundredths, input ready);
  modport sink(input valid, input usage_whole, input usage_hundredths,
               input peak_whole, input peak_hundredths, output ready);
endinterface

`default_nettype wire

FILE: rtl/cpu_load_percent_meter.sv
`default_nettype none

// cpu load meter from idle-loop counts. each sample transaction (mode 0) carries the
// idle-loop count of one window; a count at or above the stored reference becomes the
// new reference and reads as zero load (the first sample after reset calibrates this
// way), a lower count gives load = 100*(reference - count)/reference in whole percent
// plus two decimal digits, and updates the running peak. a clear transaction (mode 1)
// zeroes the peak and reports the current load. every transaction returns exactly one
// result transaction. all arithmetic runs through one shared add/subtract unit: a
// sample below the reference runs two compare/subtract steps, then two passes of a
// two-step shift-add x100 and a 7-step restoring divide, then a peak update; a
// recalibrating sample goes from the compare straight to the result, a clear from
// idle. the sample side is ready only while the sequencer is idle, and a finished
// result sits in an output register so the next sample can be taken while it waits.

module cpu_load_percent_meter (
  input wire logic          clk,
  input wire logic          rst,
  cplm_sample_if.sink       sample,
  cplm_result_if.source     result
);

  cplm_pkg::core_req_t  req;
  cplm_pkg::core_stat_t stat;
  logic                 out_free;

  // output register is free when empty or being drained this cycle
  assign out_free = ~result.valid | result.ready;

  // input is taken only while the sequencer sits idle
  assign sample.ready = stat.idle;

  always_comb begin
    req.start  = sample.valid & stat.idle;
    req.mode   = sample.mode;
    req.sample = sample.idle_count[cplm_pkg::COUNT_BITS-1:0];
  end

  cplm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .out_free (out_free),
    .stat     (stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (stat.done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      result.usage_whole      <= stat.usage_whole;
      result.usage_hundredths <= stat.usage_hundredths;
      result.peak_whole       <= stat.peak_whole;
      result.peak_hundredths  <= stat.peak_hundredths;
    end
  end

`ifndef SYNTHESIS
  // a finished result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (!result.valid || result.ready))
    else $error("result overwritten while pending");

  // after a transaction is taken the sequencer is busy
  assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("input accepted while sequencer busy");

  // both fractional digits stay below one hundred
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.usage_hundredths <= 7'd99 &&
                      result.peak_hundredths <= 7'd99))
    else $error("hundredths out of range");

  // whole percent never exceeds one hundred (a zero idle count is full load)
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.usage_whole <= 7'd100 && result.peak_whole <= 7'd100))
    else $error("whole percent out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/cplm_alu.sv
`default_nettype none

module cplm_alu (
  input  wire logic [cplm_pkg::ALU_BITS-1:0] a,
  input  wire logic [cplm_pkg::ALU_BITS-1:0] b,
  input  wire logic                          sub,
  output logic      [cplm_pkg::ALU_BITS-1:0] sum,
  output logic                               borrow
);

  logic [cplm_pkg::ALU_BITS-1:0] b_op;
  logic [cplm_pkg::ALU_BITS:0]   full;

  always_comb begin
    b_op   = sub ? ~b : b;
    full   = {1'b0, a} + {1'b0, b_op} + {{cplm_pkg::ALU_BITS{1'b0}}, sub};
    sum    = full[cplm_pkg::ALU_BITS-1:0];
    // on subtract, no carry out means a < b
    borrow = sub & ~full[cplm_pkg::ALU_BITS];
  end

endmodule

`default_nettype wire

FILE: rtl/cplm_core.sv
`default_nettype none

module cplm_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cplm_pkg::core_req_t  req,
  input  wire logic                 out_free,
  output cplm_pkg::core_stat_t      stat
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_BUSY = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_PEAK = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [cplm_pkg::STEP_BITS-1:0] STEP_TOP =
    cplm_pkg::STEP_BITS'(cplm_pkg::PCT_BITS - 1);

  logic [2:0]                          state;
  logic [cplm_pkg::COUNT_BITS-1:0]     ref_count;
  logic [cplm_pkg::COUNT_BITS-1:0]     sample_r;
  logic [cplm_pkg::COUNT_BITS-1:0]     x;
  logic [cplm_pkg::ALU_BITS-1:0]       acc;
  logic [cplm_pkg::PCT_BITS-1:0]       q;
  logic [cplm_pkg::PCT_BITS-1:0]       q_next;
  logic [cplm_pkg::STEP_BITS-1:0]      step;
  logic                                pass;
  logic [cplm_pkg::PCT_BITS-1:0]       cur_whole;
  logic [cplm_pkg::PCT_BITS-1:0]       cur_frac;
  logic [cplm_pkg::PCT_BITS-1:0]       peak_whole;
  logic [cplm_pkg::PCT_BITS-1:0]       peak_frac;

  logic [cplm_pkg::ALU_BITS-1:0]       alu_a;
  logic [cplm_pkg::ALU_BITS-1:0]       alu_b;
  logic                                alu_sub;
  logic [cplm_pkg::ALU_BITS-1:0]       alu_sum;
  logic                                alu_borrow;

  cplm_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  // operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_CMP: begin
        alu_a   = cplm_pkg::ALU_BITS'(sample_r);
        alu_b   = cplm_pkg::ALU_BITS'(ref_count);
        alu_sub = 1'b1;
      end
      S_BUSY: begin
        alu_a   = cplm_pkg::ALU_BITS'(ref_count);
        alu_b   = cplm_pkg::ALU_BITS'(sample_r);
        alu_sub = 1'b1;
      end
      S_MUL1: begin
        alu_a = cplm_pkg::ALU_BITS'(x) << cplm_pkg::MUL_SH_A;
        alu_b = cplm_pkg::ALU_BITS'(x) << cplm_pkg::MUL_SH_B;
      end
      S_MUL2: begin
        alu_a = acc;
        alu_b = cplm_pkg::ALU_BITS'(x) << cplm_pkg::MUL_SH_C;
      end
      S_DIV: begin
        alu_a   = acc;
        alu_b   = cplm_pkg::ALU_BITS'(ref_count) << step;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_next = q;
    q_next[step] = ~alu_borrow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ref_count  <= '0;
      cur_whole  <= '0;
      cur_frac   <= '0;
      peak_whole <= '0;
      peak_frac  <= '0;
      pass       <= 1'b0;
      step       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            if (req.mode) begin
              peak_whole <= '0;
              peak_frac  <= '0;
              state      <= S_DONE;
            end else begin
              sample_r <= req.sample;
              state    <= S_CMP;
            end
          end
        end
        S_CMP: begin
          if (alu_borrow) begin
            state <= S_BUSY;
          end else begin
            // recalibrate
            ref_count <= sample_r;
            cur_whole <= '0;
            cur_frac  <= '0;
            state     <= S_DONE;
          end
        end
        S_BUSY: begin
          x     <= alu_sum[cplm_pkg::COUNT_BITS-1:0];
          pass  <= 1'b0;
          state <= S_MUL1;
        end
        S_MUL1: begin
          acc   <= alu_sum;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= alu_sum;
          q     <= '0;
          step  <= STEP_TOP;
          state <= S_DIV;
        end
        S_DIV: begin
          if (!alu_borrow) begin
            acc <= alu_sum;
          end
          q <= q_next;
          if (step == '0) begin
            if (!pass) begin
              cur_whole <= q_next;
              // remainder is below the reference, carry it into the fraction pass
              x     <= alu_borrow ? acc[cplm_pkg::COUNT_BITS-1:0]
                                  : alu_sum[cplm_pkg::COUNT_BITS-1:0];
              pass  <= 1'b1;
              state <= S_MUL1;
            end else begin
              cur_frac <= q_next;
              state    <= S_PEAK;
            end
          end else begin
            step <= step - cplm_pkg::STEP_BITS'(1);
          end
        end
        S_PEAK: begin
          if (peak_whole < cur_whole ||
              (peak_whole == cur_whole && peak_frac < cur_frac)) begin
            peak_whole <= cur_whole;
            peak_frac  <= cur_frac;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    stat.idle             = (state == S_IDLE);
    stat.done             = (state == S_DONE) && out_free;
    stat.usage_whole      = cur_whole;
    stat.usage_hundredths = cur_frac;
    stat.peak_whole       = peak_whole;
    stat.peak_hundredths  = peak_frac;
  end

endmodule

`default_nettype wire
